FILE: src/prst_pkg.sv
// shared types, codes and constants of the radio statistics table
package prst_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;
    localparam int MAX_ROWS          = 16;
    localparam int CMD_DEPTH         = 2;
    localparam int RES_DEPTH         = 4;

    typedef enum logic [1:0] {
        OP_RX     = 2'd0,
        OP_TX     = 2'd1,
        OP_REPORT = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_NEW       = 3'd1,
        ST_FULL      = 3'd2,
        ST_ROW       = 3'd3,
        ST_RPT_EMPTY = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_MISS,
        S_RPT_NONE,
        S_RPT_RD,
        S_RPT_ROW0,
        S_RPT_ROW1
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [15:0] channel;
        logic [15:0] protocol_id;
        logic [15:0] transmit_ticks;
        logic [15:0] listen_ticks;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [15:0] entry_channel;
        logic [15:0] entry_protocol;
        logic        direction;
        logic [31:0] packet_count;
        logic [31:0] transmit_total;
        logic [31:0] listen_total;
        logic [31:0] transmit_delta;
        logic [31:0] listen_delta;
        logic        last;
    } t_res;

    // per direction: index 0 received, index 1 sent
    typedef struct packed {
        logic [15:0]       channel;
        logic [15:0]       protocol;
        logic [1:0][31:0]  count;
        logic [1:0][31:0]  tx_sum;
        logic [1:0][31:0]  rx_sum;
        logic [1:0][31:0]  snap_tx;
        logic [1:0][31:0]  snap_rx;
    } t_entry;

endpackage

FILE: src/prst_fifo.sv
// small first-in first-out queue built from flip-flops
module prst_fifo
    import prst_pkg::*;
#(
    parameter type t_data = t_cmd,
    parameter int  DEPTH  = CMD_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_data i_data,
    input  logic  i_rd,
    output t_data o_data,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data          r_mem [DEPTH];
    logic [PW-1:0]  r_wp, n_wp;
    logic [PW-1:0]  r_rp, n_rp;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           wr_ok, rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_ok) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_ok) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: src/prst_front.sv
// input side: accepts items, drops unused op codes, queues commands
module prst_front
    import prst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    output logic  o_full,
    input  logic  i_cmd_pop,
    output t_cmd  o_cmd,
    output logic  o_cmd_empty
);

    logic accept;
    logic keep;

    assign accept = i_push && !o_full;
    // unused op code leaves no trace
    assign keep   = (i_cmd.op != OP_NONE);

    prst_fifo #(
        .t_data (t_cmd),
        .DEPTH  (CMD_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept && keep),
        .i_data  (i_cmd),
        .i_rd    (i_cmd_pop),
        .o_data  (o_cmd),
        .o_full  (o_full),
        .o_empty (o_cmd_empty)
    );

endmodule

FILE: src/prst_back.sv
// back end: table memory and the sequencer for lookup, update and report
module prst_back
    import prst_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_match_protocol,
    input  logic  i_cmd_empty,
    input  t_cmd  i_cmd,
    output logic  o_cmd_pop,
    input  logic  i_res_full,
    output logic  o_res_push,
    output t_res  o_res
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ROW_W = $clog2(MAX_ROWS + 1);
    localparam int CMP_W = (CNT_W > ROW_W) ? CNT_W : ROW_W;

    t_entry            r_mem [TABLE_ENTRIES];
    t_entry            r_rd;
    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic [IDX_W-1:0]  r_pend_idx, n_pend_idx;

    logic              mem_re, mem_we;
    logic [IDX_W-1:0]  mem_ra, mem_wa;
    t_entry            mem_wd;

    logic              dir;
    logic              key_hit;
    logic [CMP_W-1:0]  idx_x, cnt_x, rows_x;
    logic              in_rows, row_last, walk_done;
    t_entry            fresh, snap;

    function automatic t_entry bump(input t_entry e, input logic d,
                                    input logic [15:0] tx, input logic [15:0] rx);
        t_entry r;
        r           = e;
        r.count[d]  = e.count[d] + 32'd1;
        r.tx_sum[d] = e.tx_sum[d] + {16'd0, tx};
        r.rx_sum[d] = e.rx_sum[d] + {16'd0, rx};
        return r;
    endfunction

    function automatic t_res make_row(input t_status s, input t_entry e, input logic d,
                                      input logic with_delta, input logic lst);
        t_res r;
        r.status         = s;
        r.entry_channel  = e.channel;
        r.entry_protocol = e.protocol;
        r.direction      = d;
        r.packet_count   = e.count[d];
        r.transmit_total = e.tx_sum[d];
        r.listen_total   = e.rx_sum[d];
        r.transmit_delta = with_delta ? e.tx_sum[d] - e.snap_tx[d] : 32'd0;
        r.listen_delta   = with_delta ? e.rx_sum[d] - e.snap_rx[d] : 32'd0;
        r.last           = lst;
        return r;
    endfunction

    assign dir     = (r_cmd.op == OP_TX);
    assign key_hit = (r_rd.channel == r_cmd.channel) &&
                     (!i_match_protocol || (r_rd.protocol == r_cmd.protocol_id));

    assign idx_x     = CMP_W'(r_idx);
    assign cnt_x     = CMP_W'(r_count);
    assign rows_x    = (cnt_x > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS) : cnt_x;
    assign in_rows   = (idx_x < CMP_W'(MAX_ROWS));
    assign row_last  = ((idx_x + 1'b1) == rows_x);
    assign walk_done = ((r_idx + 1'b1) == r_count);

    always_comb begin
        fresh          = '0;
        fresh.channel  = r_cmd.channel;
        fresh.protocol = r_cmd.protocol_id;
        snap           = r_rd;
        snap.snap_tx   = r_rd.tx_sum;
        snap.snap_rx   = r_rd.rx_sum;
    end

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        mem_re     = 1'b0;
        mem_ra     = r_idx[IDX_W-1:0];
        mem_we     = 1'b0;
        mem_wa     = r_idx[IDX_W-1:0];
        mem_wd     = snap;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    case (i_cmd.op)
                        OP_RX, OP_TX: n_state = S_SCAN;
                        OP_REPORT:    n_state = (r_count == '0) ? S_RPT_NONE : S_RPT_RD;
                        default:      n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                // one read issued per cycle, compared with the key in the cycle after
                if (r_pend && key_hit) begin
                    n_pend  = 1'b0;
                    n_state = S_UPD;
                end else if (r_idx != r_count) begin
                    mem_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[IDX_W-1:0];
                    n_idx      = r_idx + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_MISS;
                end
            end
            S_UPD: begin
                if (!i_res_full) begin
                    mem_we     = 1'b1;
                    mem_wa     = r_pend_idx;
                    mem_wd     = bump(r_rd, dir, r_cmd.transmit_ticks, r_cmd.listen_ticks);
                    o_res_push = 1'b1;
                    o_res      = make_row(ST_HIT, mem_wd, dir, 1'b0, 1'b1);
                    n_state    = S_IDLE;
                end
            end
            S_MISS: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                    if (r_count != CNT_W'(TABLE_ENTRIES)) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_count[IDX_W-1:0];
                        mem_wd  = bump(fresh, dir, r_cmd.transmit_ticks, r_cmd.listen_ticks);
                        n_count = r_count + 1'b1;
                        o_res   = make_row(ST_NEW, mem_wd, dir, 1'b0, 1'b1);
                    end else begin
                        // dropped: packet key and direction, zero figures
                        o_res                = '0;
                        o_res.status         = ST_FULL;
                        o_res.entry_channel  = r_cmd.channel;
                        o_res.entry_protocol = r_cmd.protocol_id;
                        o_res.direction      = dir;
                        o_res.last           = 1'b1;
                    end
                end
            end
            S_RPT_NONE: begin
                if (!i_res_full) begin
                    o_res_push   = 1'b1;
                    o_res        = '0;
                    o_res.status = ST_RPT_EMPTY;
                    o_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RPT_RD: begin
                mem_re  = 1'b1;
                n_state = S_RPT_ROW0;
            end
            S_RPT_ROW0: begin
                if (in_rows) begin
                    if (!i_res_full) begin
                        o_res_push = 1'b1;
                        o_res      = make_row(ST_ROW, r_rd, 1'b0, 1'b1, 1'b0);
                        n_state    = S_RPT_ROW1;
                    end
                end else begin
                    // beyond the reported rows: snapshot only
                    mem_we  = 1'b1;
                    n_idx   = r_idx + 1'b1;
                    n_state = walk_done ? S_IDLE : S_RPT_RD;
                end
            end
            S_RPT_ROW1: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res      = make_row(ST_ROW, r_rd, 1'b1, 1'b1, row_last);
                    mem_we     = 1'b1;
                    n_idx      = r_idx + 1'b1;
                    n_state    = walk_done ? S_IDLE : S_RPT_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pend_idx <= n_pend_idx;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

endmodule

FILE: src/per_channel_radio_stats_table_top.sv
// top level of the per-channel radio statistics table
//
// keyed statistics table for radio packet events. a received or sent packet
// item searches the table in allocation order for its key (channel, or
// channel plus protocol id when match_protocol is 1) and adds one to the
// packet count and its ticks to the totals of that direction; a miss
// allocates the next entry, zeroed, or drops the packet with status "full"
// once every entry is used. a report item walks all used entries in order,
// gives a received and a sent row per entry (the first sixteen entries
// only) with totals and deltas since the previous report, then snapshots
// the totals. timing: the table sits in one single-port-read memory with a
// registered read; a packet item scans one entry per cycle. an input queue
// of two items and a result queue of four items let input and output stall
// on their own. entries never read before allocation, so the memory needs
// no clearing pass after reset. match_protocol resets to 1 and is written
// whenever i_cfg_we is high; the user must write it only while the block is
// idle, the block itself does not enforce this. a report on an empty table
// gives a single row with the empty-report status.
module per_channel_radio_stats_table_top
    import prst_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input items
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_channel,
    input  logic [15:0] i_protocol_id,
    input  logic [15:0] i_transmit_ticks,
    input  logic [15:0] i_listen_ticks,
    // result items
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_status,
    output logic [15:0] o_entry_channel,
    output logic [15:0] o_entry_protocol,
    output logic        o_direction,
    output logic [31:0] o_packet_count,
    output logic [31:0] o_transmit_total,
    output logic [31:0] o_listen_total,
    output logic [31:0] o_transmit_delta,
    output logic [31:0] o_listen_delta,
    output logic        o_last
);

    logic  r_match_protocol;
    t_cmd  in_cmd;
    t_cmd  q_cmd;
    logic  cmd_pop;
    logic  cmd_empty;
    logic  res_push;
    logic  res_full;
    t_res  res_in;
    t_res  res_out;

    // configuration register, key mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_protocol <= 1'b1;
        end else if (i_cfg_we) begin
            r_match_protocol <= i_cfg_wdata;
        end
    end

    assign in_cmd.op             = t_op'(i_op);
    assign in_cmd.channel        = i_channel;
    assign in_cmd.protocol_id    = i_protocol_id;
    assign in_cmd.transmit_ticks = i_transmit_ticks;
    assign in_cmd.listen_ticks   = i_listen_ticks;

    // front: accepts and classifies items
    prst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (in_cmd),
        .o_full      (full),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (q_cmd),
        .o_cmd_empty (cmd_empty)
    );

    // back: table lookup, update and report walk
    prst_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_match_protocol (r_match_protocol),
        .i_cmd_empty      (cmd_empty),
        .i_cmd            (q_cmd),
        .o_cmd_pop        (cmd_pop),
        .i_res_full       (res_full),
        .o_res_push       (res_push),
        .o_res            (res_in)
    );

    // result queue, head item shown on the output ports
    prst_fifo #(
        .t_data (t_res),
        .DEPTH  (RES_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_push),
        .i_data  (res_in),
        .i_rd    (pop),
        .o_data  (res_out),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_status         = res_out.status;
    assign o_entry_channel  = res_out.entry_channel;
    assign o_entry_protocol = res_out.entry_protocol;
    assign o_direction      = res_out.direction;
    assign o_packet_count   = res_out.packet_count;
    assign o_transmit_total = res_out.transmit_total;
    assign o_listen_total   = res_out.listen_total;
    assign o_transmit_delta = res_out.transmit_delta;
    assign o_listen_delta   = res_out.listen_delta;
    assign o_last           = res_out.last;

endmodule

FILE: src/prst_check.sv
// port-level checker for the radio statistics table, bound to the top level
module prst_check
    import prst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        full,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  o_status,
    input  logic [31:0] o_packet_count,
    input  logic [31:0] o_transmit_delta,
    input  logic [31:0] o_listen_delta,
    input  logic        o_last
);

    logic single;

    // packet results and the empty report stand alone
    assign single = (o_status == ST_HIT) || (o_status == ST_NEW) ||
                    (o_status == ST_FULL) || (o_status == ST_RPT_EMPTY);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty && $stable(o_status) && $stable(o_packet_count)
                             && $stable(o_last))
        else $error("waiting item changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= ST_RPT_EMPTY))
        else $error("status code out of range");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && single) |-> o_last)
        else $error("stand-alone result without last");

    a_no_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && single) |-> (o_transmit_delta == '0) && (o_listen_delta == '0))
        else $error("delta outside a report row");

endmodule

bind per_channel_radio_stats_table_top prst_check u_prst_check (.*);

FILE: test/prst_tb_pkg.sv
// scoreboard with a statistics table predictor for the radio stats testbench
package prst_tb_pkg;
    import prst_pkg::*;

    localparam int SLOTS = TABLE_ENTRIES_DEF;

    class stats_checker;
        bit          match_protocol;
        int          slots_used;
        logic [15:0] slot_channel [SLOTS];
        logic [15:0] slot_protocol [SLOTS];
        // second index is the direction: 0 received, 1 sent
        bit   [31:0] packets [SLOTS][2];
        bit   [31:0] tx_total [SLOTS][2];
        bit   [31:0] rx_total [SLOTS][2];
        bit   [31:0] tx_snap [SLOTS][2];
        bit   [31:0] rx_snap [SLOTS][2];
        t_res        rows_due [$];
        int          mismatches;
        int          rows_seen;

        function new();
            match_protocol = 1'b1;
            slots_used     = 0;
            mismatches     = 0;
            rows_seen      = 0;
        endfunction

        function void set_match_protocol(bit v);
            match_protocol = v;
        endfunction

        function int pending();
            return rows_due.size();
        endfunction

        function t_res row(t_status st, logic [15:0] ch, logic [15:0] pr, bit dir,
                           logic [31:0] cnt, logic [31:0] tx, logic [31:0] rx,
                           logic [31:0] dtx, logic [31:0] drx, bit last);
            t_res r;
            r.status         = st;
            r.entry_channel  = ch;
            r.entry_protocol = pr;
            r.direction      = dir;
            r.packet_count   = cnt;
            r.transmit_total = tx;
            r.listen_total   = rx;
            r.transmit_delta = dtx;
            r.listen_delta   = drx;
            r.last           = last;
            return r;
        endfunction

        // works out the rows an accepted item causes and updates the table copy
        function void note_item(t_cmd c);
            int rows;
            int s;
            int d;
            int found;
            bit dir;
            t_status st;
            case (c.op)
                OP_NONE: begin
                end
                OP_REPORT: begin
                    rows = (slots_used < MAX_ROWS) ? slots_used : MAX_ROWS;
                    if (rows == 0) begin
                        rows_due.push_back(row(ST_RPT_EMPTY, '0, '0, 1'b0, '0, '0, '0,
                                               '0, '0, 1'b1));
                    end
                    for (s = 0; s < rows; s++) begin
                        for (d = 0; d < 2; d++) begin
                            rows_due.push_back(row(ST_ROW, slot_channel[s], slot_protocol[s],
                                                   d[0], packets[s][d], tx_total[s][d],
                                                   rx_total[s][d],
                                                   tx_total[s][d] - tx_snap[s][d],
                                                   rx_total[s][d] - rx_snap[s][d],
                                                   (d == 1) && (s == rows - 1)));
                        end
                    end
                    for (s = 0; s < slots_used; s++) begin
                        for (d = 0; d < 2; d++) begin
                            tx_snap[s][d] = tx_total[s][d];
                            rx_snap[s][d] = rx_total[s][d];
                        end
                    end
                end
                default: begin
                    dir   = (c.op == OP_TX);
                    found = -1;
                    for (s = 0; s < slots_used; s++) begin
                        if (found < 0 && slot_channel[s] == c.channel &&
                            (!match_protocol || slot_protocol[s] == c.protocol_id)) begin
                            found = s;
                        end
                    end
                    if (found >= 0) begin
                        st = ST_HIT;
                    end else if (slots_used < SLOTS) begin
                        found = slots_used;
                        slots_used++;
                        slot_channel[found]  = c.channel;
                        slot_protocol[found] = c.protocol_id;
                        for (d = 0; d < 2; d++) begin
                            packets[found][d]  = '0;
                            tx_total[found][d] = '0;
                            rx_total[found][d] = '0;
                            tx_snap[found][d]  = '0;
                            rx_snap[found][d]  = '0;
                        end
                        st = ST_NEW;
                    end else begin
                        rows_due.push_back(row(ST_FULL, c.channel, c.protocol_id, dir,
                                               '0, '0, '0, '0, '0, 1'b1));
                        return;
                    end
                    packets[found][dir]  = packets[found][dir] + 1;
                    tx_total[found][dir] = tx_total[found][dir] + c.transmit_ticks;
                    rx_total[found][dir] = rx_total[found][dir] + c.listen_ticks;
                    rows_due.push_back(row(st, slot_channel[found], slot_protocol[found],
                                           dir, packets[found][dir], tx_total[found][dir],
                                           rx_total[found][dir], '0, '0, 1'b1));
                end
            endcase
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("result %0d %s: got %h, expected %h",
                                          rows_seen, name, got, want));
            end
        endtask

        task check_row(t_res got);
            t_res want;
            rows_seen++;
            if (rows_due.size() == 0) begin
                report_mismatch($sformatf("result %0d (status %0d) with nothing outstanding",
                                          rows_seen, got.status));
                return;
            end
            want = rows_due.pop_front();
            check_field("status", 32'(got.status), 32'(want.status));
            check_field("entry_channel", 32'(got.entry_channel), 32'(want.entry_channel));
            check_field("entry_protocol", 32'(got.entry_protocol),
                        32'(want.entry_protocol));
            check_field("direction", 32'(got.direction), 32'(want.direction));
            check_field("packet_count", got.packet_count, want.packet_count);
            check_field("transmit_total", got.transmit_total, want.transmit_total);
            check_field("listen_total", got.listen_total, want.listen_total);
            check_field("transmit_delta", got.transmit_delta, want.transmit_delta);
            check_field("listen_delta", got.listen_delta, want.listen_delta);
            check_field("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

endpackage

FILE: test/testbench.sv
// top-level testbench of the per-channel radio statistics table
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import prst_pkg::*;
    import prst_tb_pkg::*;

    // quiet cycles after the last result
    localparam int SETTLE_CYCLES    = 120;
    // receiver hold-off long enough to back the block up into its input
    localparam int LONG_HOLD        = 400;
    localparam int RANDOM_PER_PHASE = 105;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_cfg_we         = 1'b0;
    logic        i_cfg_wdata      = 1'b0;
    logic        push             = 1'b0;
    logic        full;
    logic [1:0]  i_op             = OP_RX;
    logic [15:0] i_channel        = '0;
    logic [15:0] i_protocol_id    = '0;
    logic [15:0] i_transmit_ticks = '0;
    logic [15:0] i_listen_ticks   = '0;
    logic        empty;
    logic        pop              = 1'b0;
    logic [2:0]  o_status;
    logic [15:0] o_entry_channel;
    logic [15:0] o_entry_protocol;
    logic        o_direction;
    logic [31:0] o_packet_count;
    logic [31:0] o_transmit_total;
    logic [31:0] o_listen_total;
    logic [31:0] o_transmit_delta;
    logic [31:0] o_listen_delta;
    logic        o_last;

    stats_checker sb;
    // set by the stimulus, picked up and counted down by the receiver
    bit           hold_request = 1'b0;
    // key pool: random items mostly reuse these so that hits dominate
    logic [15:0]  pool_ch [8];
    logic [15:0]  pool_pr [3];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    per_channel_radio_stats_table_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .push             (push),
        .full             (full),
        .i_op             (i_op),
        .i_channel        (i_channel),
        .i_protocol_id    (i_protocol_id),
        .i_transmit_ticks (i_transmit_ticks),
        .i_listen_ticks   (i_listen_ticks),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_entry_channel  (o_entry_channel),
        .o_entry_protocol (o_entry_protocol),
        .o_direction      (o_direction),
        .o_packet_count   (o_packet_count),
        .o_transmit_total (o_transmit_total),
        .o_listen_total   (o_listen_total),
        .o_transmit_delta (o_transmit_delta),
        .o_listen_delta   (o_listen_delta),
        .o_last           (o_last)
    );

    function automatic t_cmd make_cmd(t_op op, logic [15:0] ch, logic [15:0] pr,
                                      logic [15:0] tx, logic [15:0] rx);
        t_cmd c;
        c.op             = op;
        c.channel        = ch;
        c.protocol_id    = pr;
        c.transmit_ticks = tx;
        c.listen_ticks   = rx;
        return c;
    endfunction

    // tick values lean on the extremes now and then
    function automatic logic [15:0] pick_ticks();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'h0000;
        if (r < 20) return 16'hffff;
        return 16'($urandom);
    endfunction

    // mostly back to back or short gaps, a few long ones
    function automatic int pick_gap(bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // well-formed traffic on pooled keys, with some reports, some stray keys
    // (new entries or drops once the table is full) and a few unused op codes
    function automatic t_cmd random_cmd();
        t_cmd c;
        int   r;
        r = $urandom_range(0, 99);
        c.channel        = pool_ch[$urandom_range(0, 7)];
        c.protocol_id    = pool_pr[$urandom_range(0, 2)];
        c.transmit_ticks = pick_ticks();
        c.listen_ticks   = pick_ticks();
        c.op             = $urandom_range(0, 1) ? OP_TX : OP_RX;
        if (r < 9) begin
            c.op = OP_REPORT;
        end else if (r < 12) begin
            c.op = OP_NONE;
        end else if (r < 18) begin
            c.channel     = 16'($urandom);
            c.protocol_id = 16'($urandom);
        end
        return c;
    endfunction

    // offer one item from the falling edge until it is taken; push stays high
    // unless a gap follows, so back-to-back items need no extra edge
    task automatic send_cmd(t_cmd c, int gap);
        @(negedge i_clk);
        push             <= 1'b1;
        i_op             <= c.op;
        i_channel        <= c.channel;
        i_protocol_id    <= c.protocol_id;
        i_transmit_ticks <= c.transmit_ticks;
        i_listen_ticks   <= c.listen_ticks;
        do @(posedge i_clk); while (full !== 1'b0);
        sb.note_item(c);
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop sending and wait until every outstanding result has been taken,
    // then wait out the settle time; unused op codes never enter the queue
    task automatic drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_match_protocol(bit v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.set_match_protocol(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random phase; unused op codes do not count toward the item total
    task automatic run_random(int items, bit with_hold);
        int   counted;
        int   gap;
        bit   steady;
        t_cmd c;
        counted = 0;
        steady  = 1'b0;
        // receiver holds off while a burst is offered back to back
        if (with_hold) hold_request = 1'b1;
        while (counted < items) begin
            if (counted % 20 == 0) steady = ($urandom_range(0, 3) == 0);
            c   = random_cmd();
            gap = (with_hold && counted < 12) ? 0 : pick_gap(steady);
            send_cmd(c, gap);
            if (c.op != OP_NONE) counted++;
        end
    endtask

    // stimulus and verdict
    initial begin
        int i;
        sb = new();
        pool_ch[0] = 16'h0000;
        pool_ch[7] = 16'hffff;
        // low bits keep the random channels apart from each other and the ends
        for (i = 1; i < 7; i++) pool_ch[i] = {13'($urandom), 3'(i)};
        pool_pr[0] = 16'h0000;
        pool_pr[1] = 16'hffff;
        pool_pr[2] = 16'($urandom);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, key is channel plus protocol after reset
        send_cmd(make_cmd(OP_REPORT, 16'h1357, 16'h2468, 16'hffff, 16'h0000), pick_gap(1'b0));
        send_cmd(make_cmd(OP_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff), pick_gap(1'b0));
        send_cmd(make_cmd(OP_RX, 16'h0000, 16'h0000, 16'hffff, 16'hffff), pick_gap(1'b0));
        send_cmd(make_cmd(OP_TX, 16'h0000, 16'h0000, 16'h0000, 16'h0000), pick_gap(1'b0));
        send_cmd(make_cmd(OP_RX, 16'hffff, 16'hffff, 16'hffff, 16'h0000), pick_gap(1'b0));
        // same channel, other protocol: a separate entry here
        send_cmd(make_cmd(OP_RX, 16'hffff, 16'h0000, 16'h0001, 16'hffff), pick_gap(1'b0));
        send_cmd(make_cmd(OP_TX, 16'hffff, 16'hffff, 16'h1234, 16'hffff), pick_gap(1'b0));
        send_cmd(make_cmd(OP_REPORT, 16'h0000, 16'h0000, 16'h0000, 16'h0000), pick_gap(1'b0));
        send_cmd(make_cmd(OP_RX, 16'h0000, 16'h0000, 16'h0010, 16'h0020), pick_gap(1'b0));
        // deltas now count from the previous snapshot
        send_cmd(make_cmd(OP_REPORT, 16'hffff, 16'hffff, 16'hffff, 16'hffff), pick_gap(1'b0));
        send_cmd(make_cmd(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                          16'($urandom)), pick_gap(1'b0));
        drain();

        // channel-only key: first entry on the channel wins, whatever protocol
        write_match_protocol(1'b0);
        send_cmd(make_cmd(OP_RX, 16'hffff, 16'h1234, 16'h0100, 16'h0200), pick_gap(1'b0));
        // new entry keeps the allocating protocol id
        send_cmd(make_cmd(OP_TX, 16'h5555, 16'haaaa, 16'h0003, 16'h0004), pick_gap(1'b0));
        send_cmd(make_cmd(OP_TX, 16'h5555, 16'h0000, 16'h0005, 16'h0006), pick_gap(1'b0));
        send_cmd(make_cmd(OP_REPORT, 16'h0000, 16'hffff, 16'h0000, 16'hffff), pick_gap(1'b0));

        // random phases across both key settings; the table fills up and
        // stray keys are dropped later on
        run_random(RANDOM_PER_PHASE, 1'b0);
        drain();
        write_match_protocol(1'b1);
        run_random(RANDOM_PER_PHASE, 1'b1);
        drain();
        write_match_protocol(1'b0);
        run_random(RANDOM_PER_PHASE, 1'b0);
        drain();

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // receiver: pop chosen at the falling edge, result taken at the rising edge
    initial begin
        int   r;
        int   hold_left;
        int   stall_left;
        int   steady_left;
        t_res got;
        hold_left   = 0;
        stall_left  = 0;
        steady_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (steady_left > 0) begin
                steady_left--;
                pop <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                // occasional stretch with no stalls at all
                if (r < 2) steady_left = $urandom_range(30, 150);
                else if (r < 6) stall_left = $urandom_range(15, 70);
                else if (r < 30) stall_left = $urandom_range(1, 3);
                pop <= (stall_left == 0);
            end
            @(posedge i_clk);
            if (pop === 1'b1 && empty === 1'b0) begin
                got.status         = t_status'(o_status);
                got.entry_channel  = o_entry_channel;
                got.entry_protocol = o_entry_protocol;
                got.direction      = o_direction;
                got.packet_count   = o_packet_count;
                got.transmit_total = o_transmit_total;
                got.listen_total   = o_listen_total;
                got.transmit_delta = o_transmit_delta;
                got.listen_delta   = o_listen_delta;
                got.last           = o_last;
                sb.check_row(got);
            end
        end
    end

    // watchdog, far above the slowest correct run
    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
src/prst_pkg.sv
src/prst_fifo.sv
src/prst_front.sv
src/prst_back.sv
src/per_channel_radio_stats_table_top.sv
src/prst_check.sv
test/prst_tb_pkg.sv
test/testbench.sv
